[rtl/core/fcre_pkg.sv]
// ----------------------------------------------------------------------------
// fcre_pkg
// Shared constants and controller/datapath interface types for the
// framed capture record extractor.
// ----------------------------------------------------------------------------
package fcre_pkg;

    localparam logic [31:0] FRAME_MAGIC   = 32'hCAFEBABE;
    localparam logic [31:0] MAGIC_BYTES   = 32'd4;
    localparam logic [31:0] FRAME_PREFIX  = 32'd8;   // magic + length word
    localparam logic [31:0] FRAME_HEAD    = 32'd24;  // prefix + capture header
    localparam logic [31:0] CAP_HEAD      = 32'd16;
    localparam logic [31:0] FRAME_TAIL    = 32'd4;
    localparam logic [31:0] LEN_LAST_OFF  = 32'd7;   // last byte of length word
    localparam logic [31:0] CAP_FIRST_OFF = 32'd16;  // capture length, header word 2
    localparam logic [31:0] CAP_END_OFF   = 32'd20;
    localparam logic [3:0]  HDR_LAST_IDX  = 4'd15;

    typedef struct packed {
        logic step;      // input beat accepted
        logic hdr_next;  // header beat taken, load next header byte
    } fcre_cmd_t;

    typedef struct packed {
        logic emit_one;   // current byte yields one payload beat
        logic emit_burst; // current byte releases the buffered header
        logic hdr_last;   // next header load is the final one
    } fcre_status_t;

endpackage

[rtl/core/framed_capture_record_extractor.sv]
// ----------------------------------------------------------------------------
// framed_capture_record_extractor
// Strips the frame wrapper from a byte stream of capture records.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one beat per byte of the framed buffer, with the buffer length
//   and a flag on the buffer's final byte (the parser rearms after it).
//   m_ channel: bytes of extracted capture records, header then payload, with
//   run_last on the last beat caused by one input byte, record_last on a
//   record's final byte and a wrapping count of bytes sent so far.
//   The output is registered: the first beat caused by an input byte appears
//   in the cycle after that byte is accepted. Throughput: one input byte per
//   cycle while the output register is empty or taken. The byte that completes
//   a record's header releases the 16 buffered header bytes; the input then
//   stays closed while they drain at one beat per cycle while m_ready is high.
//   A stalled receiver holds the output register; one further input byte is
//   taken only as the waiting beat leaves.
//   Reset (aresetn low, synchronous) empties the output and clears parse state
//   and the byte count; the header buffer is not cleared.
// ----------------------------------------------------------------------------
module framed_capture_record_extractor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic [31:0] s_buffer_length,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_run_last,
    output logic        m_record_last,
    output logic [31:0] m_bytes_total
);
    import fcre_pkg::*;

    fcre_cmd_t    cmd;
    fcre_status_t status;

    fcre_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    fcre_dpath u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_data_byte     (s_data_byte),
        .s_buffer_length (s_buffer_length),
        .s_last_byte     (s_last_byte),
        .m_out_byte      (m_out_byte),
        .m_run_last      (m_run_last),
        .m_record_last   (m_record_last),
        .m_bytes_total   (m_bytes_total)
    );

endmodule

[rtl/core/fcre_dpath.sv]
// ----------------------------------------------------------------------------
// fcre_dpath
// Parse registers, header buffer and output register of the extractor.
// ----------------------------------------------------------------------------
module fcre_dpath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  fcre_pkg::fcre_cmd_t   cmd,
    output fcre_pkg::fcre_status_t status,
    input  logic [7:0]            s_data_byte,
    input  logic [31:0]           s_buffer_length,
    input  logic                  s_last_byte,
    output logic [7:0]            m_out_byte,
    output logic                  m_run_last,
    output logic                  m_record_last,
    output logic [31:0]           m_bytes_total
);
    import fcre_pkg::*;

    logic [31:0] pos_reg, pos_next;
    logic [31:0] offset_reg, offset_next;
    logic [31:0] magic_reg, magic_next;
    logic [31:0] rec_len_reg, rec_len_next;
    logic [31:0] cap_reg, cap_next;
    logic        halted_reg, halted_next;
    logic [31:0] count_reg;

    logic [7:0]  hdr_mem [16];
    logic [3:0]  hdr_idx_reg;
    logic        cap_zero_reg;
    logic [31:0] start_reg;
    logic [32:0] pay_end_reg;    // capture length + 24
    logic [32:0] trail_end_reg;  // capture length + 27
    logic [33:0] fit_end_reg;    // record start + 28 + capture length

    logic [7:0]  out_byte_reg;
    logic        run_last_reg;
    logic        rec_last_reg;

    logic [32:0] r_ext;
    logic [32:0] r_inc;
    logic        head_over;
    logic        fit_over;
    logic        halt_set;
    logic        advance;
    logic        emit_one;
    logic        emit_burst;
    logic        rec_last_c;
    logic        hdr_we;
    logic [3:0]  hdr_addr;
    logic        load_out;

    assign r_ext     = {1'b0, offset_reg};
    assign r_inc     = r_ext + 33'd1;
    assign head_over = ({1'b0, pos_reg} + {1'b0, FRAME_HEAD}) > {1'b0, s_buffer_length};
    assign fit_over  = fit_end_reg > {2'b00, s_buffer_length};
    assign hdr_addr  = offset_reg[3:0] - FRAME_PREFIX[3:0];

    always_comb begin
        pos_next     = pos_reg;
        offset_next  = offset_reg;
        magic_next   = magic_reg;
        rec_len_next = rec_len_reg;
        cap_next     = cap_reg;
        halted_next  = halted_reg;
        halt_set     = 1'b0;
        advance      = 1'b1;
        emit_one     = 1'b0;
        emit_burst   = 1'b0;
        rec_last_c   = 1'b0;
        hdr_we       = 1'b0;
        if (!halted_reg) begin
            if (offset_reg == 32'd0) begin
                if (head_over) begin
                    halt_set = 1'b1;
                end else begin
                    magic_next = {24'd0, s_data_byte};
                end
            end else if (offset_reg < MAGIC_BYTES) begin
                magic_next[{offset_reg[1:0], 3'b000} +: 8] = s_data_byte;
            end else if (offset_reg < FRAME_PREFIX) begin
                if (offset_reg == MAGIC_BYTES) begin
                    rec_len_next = {24'd0, s_data_byte};
                end else begin
                    rec_len_next[{offset_reg[1:0], 3'b000} +: 8] = s_data_byte;
                end
                if (offset_reg == LEN_LAST_OFF &&
                    (magic_reg != FRAME_MAGIC || rec_len_next < CAP_HEAD)) begin
                    halt_set = 1'b1;
                end
            end else if (offset_reg < FRAME_HEAD) begin
                hdr_we = 1'b1;
                if (offset_reg == CAP_FIRST_OFF) begin
                    cap_next = {24'd0, s_data_byte};
                end else if (offset_reg > CAP_FIRST_OFF && offset_reg < CAP_END_OFF) begin
                    cap_next[{offset_reg[1:0], 3'b000} +: 8] = s_data_byte;
                end
                if (offset_reg == FRAME_HEAD - 32'd1) begin
                    if (fit_over) begin
                        halt_set = 1'b1;
                    end else begin
                        emit_burst = 1'b1;
                    end
                end
            end else if (r_ext < pay_end_reg) begin
                emit_one   = 1'b1;
                rec_last_c = (r_inc == pay_end_reg);
            end else if (r_ext >= trail_end_reg) begin
                offset_next = 32'd0;
                advance     = 1'b0;
            end
            if (!halt_set && advance) begin
                offset_next = r_inc[31:0];
            end
            halted_next = halt_set;
        end
        if (pos_reg != 32'hFFFF_FFFF) begin
            pos_next = pos_reg + 32'd1;
        end
        if (s_last_byte) begin
            pos_next     = 32'd0;
            offset_next  = 32'd0;
            magic_next   = 32'd0;
            rec_len_next = 32'd0;
            cap_next     = 32'd0;
            halted_next  = 1'b0;
        end
    end

    assign load_out = (cmd.step && (emit_one || emit_burst)) || cmd.hdr_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            offset_reg  <= '0;
            magic_reg   <= '0;
            rec_len_reg <= '0;
            cap_reg     <= '0;
            halted_reg  <= 1'b0;
            count_reg   <= '0;
        end else begin
            if (cmd.step) begin
                pos_reg     <= pos_next;
                offset_reg  <= offset_next;
                magic_reg   <= magic_next;
                rec_len_reg <= rec_len_next;
                cap_reg     <= cap_next;
                halted_reg  <= halted_next;
            end
            if (load_out) begin
                count_reg <= count_reg + 32'd1;
            end
        end
    end

    // Record end bounds are registered and settle before the header completes.
    always_ff @(posedge aclk) begin
        pay_end_reg   <= {1'b0, cap_reg} + {1'b0, FRAME_HEAD};
        trail_end_reg <= {1'b0, cap_reg} + {1'b0, FRAME_HEAD} + {1'b0, FRAME_TAIL} - 33'd1;
        fit_end_reg   <= {2'b00, start_reg} + {1'b0, pay_end_reg} + {2'b00, FRAME_TAIL};
        if (cmd.step && !halted_reg && offset_reg == 32'd0) begin
            start_reg <= pos_reg;
        end
        if (cmd.step && hdr_we) begin
            hdr_mem[hdr_addr] <= s_data_byte;
        end
        if (cmd.step && emit_burst) begin
            out_byte_reg <= hdr_mem[0];
            run_last_reg <= 1'b0;
            rec_last_reg <= 1'b0;
            hdr_idx_reg  <= 4'd1;
            cap_zero_reg <= (cap_reg == 32'd0);
        end else if (cmd.step && emit_one) begin
            out_byte_reg <= s_data_byte;
            run_last_reg <= 1'b1;
            rec_last_reg <= rec_last_c;
        end else if (cmd.hdr_next) begin
            out_byte_reg <= hdr_mem[hdr_idx_reg];
            run_last_reg <= (hdr_idx_reg == HDR_LAST_IDX);
            rec_last_reg <= (hdr_idx_reg == HDR_LAST_IDX) && cap_zero_reg;
            hdr_idx_reg  <= hdr_idx_reg + 4'd1;
        end
    end

    assign status.emit_one   = emit_one;
    assign status.emit_burst = emit_burst;
    assign status.hdr_last   = (hdr_idx_reg == HDR_LAST_IDX);

    assign m_out_byte    = out_byte_reg;
    assign m_run_last    = run_last_reg;
    assign m_record_last = rec_last_reg;
    assign m_bytes_total = count_reg;

endmodule

[rtl/core/fcre_ctrl.sv]
// ----------------------------------------------------------------------------
// fcre_ctrl
// Handshake controller: input acceptance, output valid, header burst.
// ----------------------------------------------------------------------------
module fcre_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    input  fcre_pkg::fcre_status_t status,
    output fcre_pkg::fcre_cmd_t    cmd
);
    import fcre_pkg::*;

    typedef enum logic [0:0] {
        ST_RUN,
        ST_BURST
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   step;

    assign s_ready      = (state_reg == ST_RUN) && (!m_valid_reg || m_ready);
    assign step         = s_valid && s_ready;
    assign cmd.step     = step;
    assign cmd.hdr_next = (state_reg == ST_BURST) && m_ready;
    assign m_valid      = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        unique case (state_reg)
            ST_RUN: begin
                if (step && status.emit_burst) begin
                    state_next   = ST_BURST;
                    m_valid_next = 1'b1;
                end else if (step && status.emit_one) begin
                    m_valid_next = 1'b1;
                end else if (m_ready) begin
                    m_valid_next = 1'b0;
                end
            end
            ST_BURST: begin
                if (m_ready && status.hdr_last) begin
                    state_next = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_RUN;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

[rtl/core/fcre_checker.sv]
// ----------------------------------------------------------------------------
// fcre_checker
// Port-level checks for the framed capture record extractor.
// ----------------------------------------------------------------------------
module fcre_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_out_byte,
    input logic        m_run_last,
    input logic        m_record_last,
    input logic [31:0] m_bytes_total
);

    // A stalled beat holds its byte.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte))
        else $error("output beat changed while stalled");

    // Mid-burst header beats keep the input closed.
    a_burst_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_run_last |-> !s_ready)
        else $error("input opened during header burst");

    // Back-to-back beats count up by one.
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready ##1 m_valid |-> m_bytes_total == $past(m_bytes_total) + 32'd1)
        else $error("byte count skipped");

    // A record always ends on the last beat of its input byte.
    a_rec_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_record_last |-> m_run_last)
        else $error("record end not on run end");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind framed_capture_record_extractor fcre_checker u_fcre_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_out_byte    (m_out_byte),
    .m_run_last    (m_run_last),
    .m_record_last (m_record_last),
    .m_bytes_total (m_bytes_total)
);

[tb/sv/fcre_scoreboard_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcre_scoreboard_pkg
// Deframing predictor and scoreboard for the capture record extractor test.
// Each accepted input byte is run through a model of the parser, and the
// bytes it should release are queued for comparison with the output beats.
// ----------------------------------------------------------------------------
package fcre_scoreboard_pkg;

    import fcre_pkg::*;

    typedef struct {
        logic [7:0]  data;
        logic        run_last;
        logic        rec_last;
        logic [31:0] total;
    } out_beat_t;

    class fcre_scoreboard;
        out_beat_t   extracted_q[$];
        int          errors;
        int          beats_checked;
        int          records_done;

        // parser state
        logic [31:0] buf_pos;
        logic [31:0] rec_off;
        logic [31:0] magic_acc;
        logic [31:0] len_acc;
        logic [31:0] cap_len;
        logic [31:0] emitted;
        logic [7:0]  hdr_store[16];
        bit          halted;

        function new();
            rearm();
            emitted       = 32'd0;
            errors        = 0;
            beats_checked = 0;
            records_done  = 0;
        endfunction

        function void rearm();
            buf_pos   = 32'd0;
            rec_off   = 32'd0;
            magic_acc = 32'd0;
            len_acc   = 32'd0;
            cap_len   = 32'd0;
            halted    = 1'b0;
        endfunction

        function void release_byte(logic [7:0] b, logic rec_last);
            out_beat_t beat;
            emitted       = emitted + 32'd1;
            beat.data     = b;
            beat.run_last = 1'b0;
            beat.rec_last = rec_last;
            beat.total    = emitted;
            extracted_q.push_back(beat);
        endfunction

        // Accepted input beat: advance the parser, queue whatever it releases.
        function void deframe_byte(logic [7:0] b, logic [31:0] len, logic lst);
            longint unsigned pos;
            longint unsigned cap;
            longint unsigned start;
            longint unsigned blen;
            logic [31:0]     r;
            bit              adv;
            int              first;
            out_beat_t       tail_beat;
            first = extracted_q.size();
            blen  = len;
            if (!halted) begin
                r   = rec_off;
                pos = buf_pos;
                cap = cap_len;
                adv = 1'b1;
                if (r == 32'd0) begin
                    if (pos + FRAME_HEAD > blen)
                        halted = 1'b1;
                    else
                        magic_acc = {24'd0, b};
                end else if (r < MAGIC_BYTES) begin
                    magic_acc = magic_acc | ({24'd0, b} << (8 * r));
                end else if (r < FRAME_PREFIX) begin
                    if (r == MAGIC_BYTES)
                        len_acc = {24'd0, b};
                    else
                        len_acc = len_acc | ({24'd0, b} << (8 * (r - MAGIC_BYTES)));
                    if (r == LEN_LAST_OFF && (magic_acc != FRAME_MAGIC || len_acc < CAP_HEAD))
                        halted = 1'b1;
                end else if (r < FRAME_HEAD) begin
                    hdr_store[r - FRAME_PREFIX] = b;
                    if (r == CAP_FIRST_OFF)
                        cap_len = {24'd0, b};
                    else if (r > CAP_FIRST_OFF && r < CAP_END_OFF)
                        cap_len = cap_len | ({24'd0, b} << (8 * (r - CAP_FIRST_OFF)));
                    if (r == FRAME_HEAD - 32'd1) begin
                        start = pos - (FRAME_HEAD - 32'd1);
                        cap   = cap_len;
                        if (start + FRAME_HEAD + cap + FRAME_TAIL > blen) begin
                            halted = 1'b1;
                        end else begin
                            for (int i = 0; i < 16; i++)
                                release_byte(hdr_store[i], i == 15 && cap == 0);
                        end
                    end
                end else if (r < FRAME_HEAD + cap) begin
                    release_byte(b, r == FRAME_HEAD - 1 + cap);
                end else if (r >= FRAME_HEAD + cap + FRAME_TAIL - 1) begin
                    // last trailer byte: next byte opens a new record
                    rec_off = 32'd0;
                    adv     = 1'b0;
                end
                if (!halted && adv)
                    rec_off = r + 32'd1;
            end
            if (buf_pos != 32'hFFFF_FFFF)
                buf_pos = buf_pos + 32'd1;
            if (extracted_q.size() > first) begin
                tail_beat          = extracted_q.pop_back();
                tail_beat.run_last = 1'b1;
                extracted_q.push_back(tail_beat);
            end
            if (lst)
                rearm();
        endfunction

        function void field_mismatch(string what, logic [31:0] exp, logic [31:0] act);
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, exp, act);
        endfunction

        function void check_beat(logic [7:0] b, logic run_last, logic rec_last,
                                 logic [31:0] total);
            out_beat_t exp;
            if (extracted_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected output beat, expected none, got byte 0x%0h",
                         $time, b);
                return;
            end
            exp = extracted_q.pop_front();
            beats_checked++;
            if (rec_last === 1'b1)
                records_done++;
            if (b !== exp.data)
                field_mismatch("out_byte", {24'd0, exp.data}, {24'd0, b});
            if (run_last !== exp.run_last)
                field_mismatch("run_last", {31'd0, exp.run_last}, {31'd0, run_last});
            if (rec_last !== exp.rec_last)
                field_mismatch("record_last", {31'd0, exp.rec_last}, {31'd0, rec_last});
            if (total !== exp.total)
                field_mismatch("bytes_total", exp.total, total);
        endfunction

        function int pending();
            return extracted_q.size();
        endfunction
    endclass

endpackage

[tb/sv/framed_capture_record_extractor_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_capture_record_extractor_tb
// Drives framed capture buffers through the extractor and checks every output
// beat against a deframing predictor. Buffers mix well-formed records with
// bad magic, short lengths, records that do not fit, truncation, length
// changes and noise, under random idling on both sides and long output stalls.
// ----------------------------------------------------------------------------
module framed_capture_record_extractor_tb;

    import fcre_pkg::*;
    import fcre_scoreboard_pkg::*;

    typedef logic [7:0] frame_bytes_t[$];

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte     = 8'd0;
    logic [31:0] s_buffer_length = 32'd0;
    logic        s_last_byte     = 1'b0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_run_last;
    logic        m_record_last;
    logic [31:0] m_bytes_total;

    fcre_scoreboard sb = new();
    frame_bytes_t   frame_q;
    int             bytes_sent   = 0;
    int             buffers_sent = 0;
    bit             calm         = 1'b0;

    framed_capture_record_extractor u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_buffer_length (s_buffer_length),
        .s_last_byte     (s_last_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_run_last      (m_run_last),
        .m_record_last   (m_record_last),
        .m_bytes_total   (m_bytes_total)
    );

    always #4 aclk = ~aclk;

    // Inputs noted before outputs are checked on the same edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.deframe_byte(s_data_byte, s_buffer_length, s_last_byte);
            if (m_valid && m_ready)
                sb.check_beat(m_out_byte, m_run_last, m_record_last, m_bytes_total);
        end
    end

    // Receiver: random back-pressure plus two long hold-offs to fill the block.
    initial begin
        int hold_left;
        int next_hold_at;
        int holds_done;
        hold_left    = 0;
        next_hold_at = 120;
        holds_done   = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && hold_left == 0 && holds_done < 2 && bytes_sent >= next_hold_at) begin
                hold_left    = 150;
                holds_done++;
                next_hold_at = next_hold_at + 260;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm || ($urandom_range(0, 99) >= 9);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic put_byte(input logic [7:0] d, input logic [31:0] len, input logic lst);
        while (!calm && $urandom_range(0, 99) < 9) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_data_byte     <= d;
        s_buffer_length <= len;
        s_last_byte     <= lst;
        do
            @(posedge aclk);
        while (!s_ready);
        bytes_sent++;
        calm = (bytes_sent >= 200 && bytes_sent < 300);
    endtask

    // Sends frame_q as one buffer; from change_at onwards the length reads len2.
    task automatic send_buffer(input logic [31:0] len, input int change_at,
                               input logic [31:0] len2);
        for (int i = 0; i < frame_q.size(); i++)
            put_byte(frame_q[i], (change_at >= 0 && i >= change_at) ? len2 : len,
                     i == frame_q.size() - 1);
        buffers_sent++;
        frame_q.delete();
    endtask

    function automatic void append_word(logic [31:0] w);
        for (int i = 0; i < 4; i++)
            frame_q.push_back(w[8 * i +: 8]);
    endfunction

    function automatic void append_record(logic [31:0] magic, logic [31:0] rlen,
                                          logic [31:0] cap, int pay_n, bit with_tail);
        append_word(magic);
        append_word(rlen);
        for (int i = 0; i < 16; i++) begin
            if (i >= 8 && i < 12)
                frame_q.push_back(cap[8 * (i - 8) +: 8]);
            else
                frame_q.push_back(8'($urandom));
        end
        for (int i = 0; i < pay_n; i++)
            frame_q.push_back(8'($urandom));
        if (with_tail)
            append_word($urandom);
    endfunction

    function automatic logic [31:0] random_rlen();
        logic [31:0] v;
        v = $urandom;
        if (v < CAP_HEAD)
            v = v | CAP_HEAD;
        return v;
    endfunction

    function automatic logic [31:0] random_cap();
        return ($urandom_range(0, 99) < 15) ? $urandom_range(9, 40) : $urandom_range(0, 8);
    endfunction

    function automatic void append_good_record();
        logic [31:0] cap;
        cap = random_cap();
        append_record(FRAME_MAGIC, random_rlen(), cap, cap, 1'b1);
    endfunction

    initial begin
        int          kind;
        int          sub;
        int          total;
        int          cut;
        logic [31:0] mask;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: zero buffer length halts at once; then a capture-length-zero
        // record whose buffer ends right after the header.
        frame_q.push_back(8'hFF);
        send_buffer(32'd0, -1, 32'd0);
        append_record(FRAME_MAGIC, CAP_HEAD, 32'd0, 0, 1'b0);
        frame_q[8]  = 8'h00;
        frame_q[9]  = 8'hFF;
        frame_q[23] = 8'hFF;
        send_buffer(32'd28, -1, 32'd0);

        while (bytes_sent < 450) begin
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
                repeat ($urandom_range(1, 3)) append_good_record();
                total = frame_q.size();
                sub   = $urandom_range(0, 99);
                if (sub < 10) begin
                    send_buffer(32'hFFFF_FFFF, -1, 32'd0);
                end else if (sub < 22) begin
                    send_buffer(total - $urandom_range(1, 8), -1, 32'd0);
                end else if (sub < 30) begin
                    // stray bytes after the last record start one too close to the end
                    repeat ($urandom_range(1, 23)) frame_q.push_back(8'($urandom));
                    send_buffer(frame_q.size(), -1, 32'd0);
                end else begin
                    send_buffer(total, -1, 32'd0);
                end
            end else if (kind < 75) begin
                sub = $urandom_range(0, 3);
                case (sub)
                    0: begin
                        mask = $urandom;
                        if (mask == 32'd0)
                            mask = 32'd1 << $urandom_range(0, 31);
                        append_record(FRAME_MAGIC ^ mask, random_rlen(), 32'd2, 2, 1'b1);
                        append_good_record();
                        send_buffer(frame_q.size(), -1, 32'd0);
                    end
                    1: begin
                        append_record(FRAME_MAGIC, $urandom_range(0, 15), 32'd3, 3, 1'b1);
                        append_good_record();
                        send_buffer(frame_q.size(), -1, 32'd0);
                    end
                    2: begin
                        append_good_record();
                        total = frame_q.size();
                        cut   = $urandom_range(1, total - 1);
                        repeat (cut) void'(frame_q.pop_back());
                        send_buffer(total, -1, 32'd0);
                    end
                    default: begin
                        append_good_record();
                        append_good_record();
                        total = frame_q.size();
                        send_buffer(total, $urandom_range(0, total - 1),
                                    $urandom_range(0, total));
                    end
                endcase
            end else if (kind < 85) begin
                // huge capture length in an unbounded buffer: cut in the payload
                append_record(FRAME_MAGIC, random_rlen(), $urandom | 32'h40,
                              $urandom_range(0, 12), 1'b0);
                send_buffer(32'hFFFF_FFFF, -1, 32'd0);
            end else begin
                if ($urandom_range(0, 99) < 30)
                    append_word(FRAME_MAGIC);
                repeat ($urandom_range(1, 24)) frame_q.push_back(8'($urandom));
                send_buffer(($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 64),
                            -1, 32'd0);
            end
        end
        s_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Sent %0d framed bytes in %0d buffers (good, broken, cut and noise).",
                 bytes_sent, buffers_sent);
        $display("Checked %0d output beats, %0d records closed with record_last.",
                 sb.beats_checked, sb.records_done);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/fcre_pkg.sv
rtl/core/fcre_dpath.sv
rtl/core/fcre_ctrl.sv
rtl/core/framed_capture_record_extractor.sv
rtl/core/fcre_checker.sv
tb/sv/fcre_scoreboard_pkg.sv
tb/sv/framed_capture_record_extractor_tb.sv
